>>> hdl/smd_pkg.sv
package smd_pkg;

   // Widths of the result fields, fixed by the result format.
   localparam int MEAN_W  = 24;
   localparam int STD_W   = 24;
   localparam int COUNT_W = 17;

   // Saturation limits of the result fields.
   localparam logic [MEAN_W-1:0]  MEAN_POS_LIM = {1'b0, {(MEAN_W-1){1'b1}}};
   localparam logic [MEAN_W-1:0]  MEAN_NEG_LIM = {1'b1, {(MEAN_W-1){1'b0}}};
   localparam logic [STD_W-1:0]   STD_MAX      = {STD_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

endpackage

>>> hdl/smd_front.sv
module smd_front #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_COUNT   = 65536,
   parameter int CNT_W       = 17,
   parameter int SUM_W       = 33,
   parameter int SQ_W        = 47
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_last,
   input  logic                          set_full,
   output logic                          set_push,
   output logic signed [SUM_W-1:0]       set_sum,
   output logic        [SQ_W-1:0]        set_sq,
   output logic        [CNT_W-1:0]       set_count,
   output logic                          set_ovf
);

   logic signed [SUM_W-1:0]         sum_ff, sum_in;
   logic        [SQ_W-1:0]          sq_ff, sq_in;
   logic        [CNT_W-1:0]         count_ff, count_in;
   logic                            ovf_ff, ovf_in;
   logic                            accept;
   logic signed [2*SAMPLE_BITS-1:0] product;
   logic        [2*SAMPLE_BITS-2:0] square;

   assign req_stall = set_full;
   assign accept    = req_valid && !set_full;

   // The square of a sample is never negative and needs one bit less than the product.
   assign product = req_sample * req_sample;
   assign square  = product[2*SAMPLE_BITS-2:0];

   // Running values including the current sample; they go to the queue when it closes a set.
   always_comb begin
      set_sum   = sum_ff;
      set_sq    = sq_ff;
      set_count = count_ff;
      set_ovf   = ovf_ff;
      if (count_ff == CNT_W'(MAX_COUNT)) begin
         set_ovf = 1'b1;
      end else begin
         set_sum   = sum_ff + SUM_W'(req_sample);
         set_sq    = sq_ff + SQ_W'(square);
         set_count = count_ff + CNT_W'(1);
      end
   end

   assign set_push = accept && req_last;

   always_comb begin
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req_last) begin
            sum_in   = '0;
            sq_in    = '0;
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            sum_in   = set_sum;
            sq_in    = set_sq;
            count_in = set_count;
            ovf_in   = set_ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         sq_ff    <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(MAX_COUNT))
      else $error("sample count ran past its limit");

   assert property (@(posedge clock) disable iff (reset)
      set_push |=> count_ff == '0 && !ovf_ff && sum_ff == '0 && sq_ff == '0)
      else $error("accumulators not cleared after the closing sample");

endmodule

>>> hdl/smd_fifo.sv
module smd_fifo #(
   parameter int WIDTH = 98,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH) && (count_ff == '0 || count_ff == CNT_W'(DEPTH)
      || wr_ptr_ff != rd_ptr_ff))
      else $error("queue fill count disagrees with its pointers");

endmodule

>>> hdl/smd_back.sv
module smd_back #(
   parameter int FRAC_BITS = 8,
   parameter int CNT_W     = 17,
   parameter int SUM_W     = 33,
   parameter int SQ_W      = 47
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  set_valid,
   output logic                                  set_pop,
   input  logic signed [SUM_W-1:0]               set_sum,
   input  logic        [SQ_W-1:0]                set_sq,
   input  logic        [CNT_W-1:0]               set_count,
   input  logic                                  set_ovf,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [smd_pkg::MEAN_W-1:0]     rsp_mean_value,
   output logic        [smd_pkg::STD_W-1:0]      rsp_std_deviation,
   output logic        [smd_pkg::COUNT_W-1:0]    rsp_sample_count,
   output logic                                  rsp_count_overflow
);

   import smd_pkg::*;

   localparam int MAG_W   = SUM_W - 1;
   localparam int DIFF_W  = SQ_W + CNT_W;
   localparam int DEN_W   = 2 * CNT_W;
   localparam int VNUM_W  = DIFF_W + 2 * FRAC_BITS;
   localparam int ROOT_W  = (VNUM_W + 1) / 2;
   localparam int DIV_W   = 2 * ROOT_W;
   localparam int CTR_W   = $clog2(DIV_W);
   localparam int QX_W    = ((DIV_W > MEAN_W) ? DIV_W : MEAN_W) + 1;
   localparam int SX_W    = (ROOT_W > STD_W) ? ROOT_W : STD_W;
   localparam int CX_W    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_MUL_NQ   = 8'b0000_0010,
      ST_MUL_SS   = 8'b0000_0100,
      ST_DIFF     = 8'b0000_1000,
      ST_DIV_VAR  = 8'b0001_0000,
      ST_ROOT     = 8'b0010_0000,
      ST_DIV_MEAN = 8'b0100_0000,
      ST_WRITE    = 8'b1000_0000
   } back_state_type;

   back_state_type       state_ff, state_in;
   logic [CTR_W-1:0]     step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 neg_ff, neg_in;
   logic [MAG_W-1:0]     smag_ff, smag_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic                 ovf_ff, ovf_in;
   logic [DEN_W-1:0]     d_ff, d_in;
   logic [DIFF_W-1:0]    nq_ff, nq_in;
   logic [DIFF_W-1:0]    mcand_ff, mcand_in;
   logic [MAG_W-1:0]     mplier_ff, mplier_in;
   logic [DIFF_W-1:0]    acc_ff, acc_in;
   logic [DIV_W-1:0]     num_ff, num_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [ROOT_W:0]      srem_ff, srem_in;

   logic signed [MEAN_W-1:0] rsp_mean_ff, rsp_mean_in;
   logic [STD_W-1:0]     rsp_std_ff, rsp_std_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   logic [SUM_W-1:0]     sum_abs;
   logic [CNT_W-1:0]     n_m1;
   logic [DIFF_W-1:0]    acc_step;
   logic [DIFF_W-1:0]    diff;
   logic [DEN_W:0]       div_shift;
   logic [DEN_W:0]       div_sub;
   logic                 div_bit;
   logic [ROOT_W+2:0]    sq_shift;
   logic [ROOT_W+2:0]    sq_trial;
   logic [ROOT_W+2:0]    sq_diff;
   logic                 sq_bit;
   logic [QX_W-1:0]      mean_q;
   logic [MEAN_W-1:0]    mean_mag;
   logic [SX_W-1:0]      root_x;
   logic [CX_W-1:0]      n_x;

   // Values taken from the set at the head of the queue.
   assign sum_abs = set_sum[SUM_W-1] ? SUM_W'(-set_sum) : SUM_W'(set_sum);
   assign n_m1    = set_count - CNT_W'(1);

   // One bit of a shift-and-add multiply.
   assign acc_step = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;

   assign diff = (nq_ff > acc_ff) ? nq_ff - acc_ff : '0;

   // One bit of a restoring division; the quotient shifts into the numerator register.
   assign div_shift = {rem_ff, num_ff[DIV_W-1]};
   assign div_sub   = div_shift - {1'b0, den_ff};
   assign div_bit   = (div_shift >= {1'b0, den_ff});

   // One bit of the digit-by-digit square root, two radicand bits per step.
   // The partial remainder can reach twice the partial root, one bit above the root.
   assign sq_shift = {srem_ff, num_ff[DIV_W-1 -: 2]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_diff  = sq_shift - sq_trial;
   assign sq_bit   = (sq_shift >= sq_trial);

   // Result formatting: round the negative mean toward minus infinity and saturate.
   assign mean_q = QX_W'(num_ff) + QX_W'(neg_ff && rem_ff != '0);
   always_comb begin
      if (neg_ff) begin
         mean_mag = (mean_q > QX_W'(MEAN_NEG_LIM)) ? MEAN_NEG_LIM : mean_q[MEAN_W-1:0];
      end else begin
         mean_mag = (mean_q > QX_W'(MEAN_POS_LIM)) ? MEAN_POS_LIM : mean_q[MEAN_W-1:0];
      end
   end
   assign root_x = SX_W'(root_ff);
   assign n_x    = CX_W'(n_ff);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      set_pop      = 1'b0;
      neg_in       = neg_ff;
      smag_in      = smag_ff;
      n_in         = n_ff;
      ovf_in       = ovf_ff;
      d_in         = d_ff;
      nq_in        = nq_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      acc_in       = acc_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      root_in      = root_ff;
      srem_in      = srem_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_std_in   = rsp_std_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (set_valid) begin
               set_pop   = 1'b1;
               neg_in    = set_sum[SUM_W-1];
               smag_in   = sum_abs[MAG_W-1:0];
               n_in      = set_count;
               ovf_in    = set_ovf;
               d_in      = DEN_W'(set_count) * DEN_W'(n_m1);
               mcand_in  = DIFF_W'(set_sq);
               mplier_in = MAG_W'(set_count);
               acc_in    = '0;
               step_in   = '0;
               state_in  = ST_MUL_NQ;
            end
         end
         ST_MUL_NQ: begin
            acc_in    = acc_step;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff + CTR_W'(1);
            if (step_ff == CTR_W'(CNT_W - 1)) begin
               nq_in     = acc_step;
               mcand_in  = DIFF_W'(smag_ff);
               mplier_in = smag_ff;
               acc_in    = '0;
               step_in   = '0;
               state_in  = ST_MUL_SS;
            end
         end
         ST_MUL_SS: begin
            acc_in    = acc_step;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff + CTR_W'(1);
            if (step_ff == CTR_W'(MAG_W - 1)) begin
               step_in  = '0;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            num_in   = DIV_W'(diff) << (2 * FRAC_BITS);
            rem_in   = '0;
            den_in   = d_ff;
            step_in  = '0;
            state_in = ST_DIV_VAR;
         end
         ST_DIV_VAR: begin
            num_in  = {num_ff[DIV_W-2:0], div_bit};
            rem_in  = div_bit ? div_sub[DEN_W-1:0] : div_shift[DEN_W-1:0];
            step_in = step_ff + CTR_W'(1);
            if (step_ff == CTR_W'(DIV_W - 1)) begin
               root_in  = '0;
               srem_in  = '0;
               step_in  = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            num_in  = num_ff << 2;
            root_in = {root_ff[ROOT_W-2:0], sq_bit};
            srem_in = sq_bit ? sq_diff[ROOT_W:0] : sq_shift[ROOT_W:0];
            step_in = step_ff + CTR_W'(1);
            if (step_ff == CTR_W'(ROOT_W - 1)) begin
               num_in   = DIV_W'(smag_ff) << FRAC_BITS;
               rem_in   = '0;
               den_in   = DEN_W'(n_ff);
               step_in  = '0;
               state_in = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN: begin
            num_in  = {num_ff[DIV_W-2:0], div_bit};
            rem_in  = div_bit ? div_sub[DEN_W-1:0] : div_shift[DEN_W-1:0];
            step_in = step_ff + CTR_W'(1);
            if (step_ff == CTR_W'(DIV_W - 1)) begin
               step_in  = '0;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ovf_in   = ovf_ff;
               rsp_count_in = (n_x > CX_W'(COUNT_MAX)) ? COUNT_MAX : n_x[COUNT_W-1:0];
               if (ovf_ff) begin
                  rsp_mean_in = '0;
               end else begin
                  rsp_mean_in = neg_ff ? signed'(MEAN_W'(-mean_mag)) : signed'(mean_mag);
               end
               if (ovf_ff || n_ff < CNT_W'(2)) begin
                  rsp_std_in = '0;
               end else begin
                  rsp_std_in = (root_x > SX_W'(STD_MAX)) ? STD_MAX : root_x[STD_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff       <= neg_in;
      smag_ff      <= smag_in;
      n_ff         <= n_in;
      ovf_ff       <= ovf_in;
      d_ff         <= d_in;
      nq_ff        <= nq_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      acc_ff       <= acc_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      root_ff      <= root_in;
      srem_ff      <= srem_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_std_ff   <= rsp_std_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mean_value     = rsp_mean_ff;
   assign rsp_std_deviation  = rsp_std_ff;
   assign rsp_sample_count   = rsp_count_ff;
   assign rsp_count_overflow = rsp_ovf_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |-> rsp_mean_ff == '0 && rsp_std_ff == '0)
      else $error("overflowed set reported a nonzero mean or deviation");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_count_ff < COUNT_W'(2) |-> rsp_std_ff == '0)
      else $error("single-sample set reported a nonzero deviation");

   assert property (@(posedge clock) disable iff (reset)
      set_pop |-> state_ff == ST_IDLE && set_valid)
      else $error("queue popped outside of the idle state");

endmodule

>>> hdl/sequence_mean_stddev.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_sample (signed), req_last
// rsp       out        rsp_valid/rsp_stall  rsp_mean_value, rsp_std_deviation,
//                                           rsp_sample_count, rsp_count_overflow
//
// Samples are taken one per cycle; a set costs nothing extra at the input as long as the
// two-entry set queue has room, and req_stall is high only while that queue is full.
// The back end takes one set at a time through its one-bit-per-cycle multiplier,
// divider and square-root steps.
// Reset is synchronous and active high; it clears the accumulators, the queue and the
// result valid flag. A stalled result holds, and the back end keeps working on the next set.
module sequence_mean_stddev #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_COUNT   = 65536,
   parameter int FRAC_BITS   = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [smd_pkg::MEAN_W-1:0]     rsp_mean_value,
   output logic        [smd_pkg::STD_W-1:0]      rsp_std_deviation,
   output logic        [smd_pkg::COUNT_W-1:0]    rsp_sample_count,
   output logic                                  rsp_count_overflow
);

   import smd_pkg::*;

   // The count must hold MAX_COUNT itself. The sum magnitude stays below
   // 2^(SAMPLE_BITS-1) * 2^CNT_W, and each square is at most 2^(2*SAMPLE_BITS-2).
   localparam int CNT_W       = $clog2(MAX_COUNT + 1);
   localparam int SUM_W       = SAMPLE_BITS + CNT_W;
   localparam int SQ_W        = 2 * SAMPLE_BITS - 2 + CNT_W;
   localparam int SET_W       = 1 + CNT_W + SQ_W + SUM_W;
   localparam int QUEUE_DEPTH = 2;

   logic                    set_push;
   logic                    set_full;
   logic signed [SUM_W-1:0] front_sum;
   logic [SQ_W-1:0]         front_sq;
   logic [CNT_W-1:0]        front_count;
   logic                    front_ovf;
   logic [SET_W-1:0]        push_data;
   logic [SET_W-1:0]        pop_data;
   logic                    pop_valid;
   logic                    set_pop;

   // The front end accumulates count, sum and sum of squares at the input rate and hands
   // a finished set to the queue on the transfer that carries the last marker.
   smd_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_COUNT   (MAX_COUNT),
      .CNT_W       (CNT_W),
      .SUM_W       (SUM_W),
      .SQ_W        (SQ_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .req_last   (req_last),
      .set_full   (set_full),
      .set_push   (set_push),
      .set_sum    (front_sum),
      .set_sq     (front_sq),
      .set_count  (front_count),
      .set_ovf    (front_ovf)
   );

   assign push_data = {front_ovf, front_count, front_sq, front_sum};

   // The queue lets a new set accumulate while the back end is still busy on an older one.
   smd_fifo #(
      .WIDTH (SET_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (set_push),
      .push_data (push_data),
      .full      (set_full),
      .pop       (set_pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   // The back end forms n*Q and S^2, divides for the variance and the mean, takes the
   // square root and holds the finished result in its output register.
   smd_back #(
      .FRAC_BITS (FRAC_BITS),
      .CNT_W     (CNT_W),
      .SUM_W     (SUM_W),
      .SQ_W      (SQ_W)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .set_valid          (pop_valid),
      .set_pop            (set_pop),
      .set_sum            (signed'(pop_data[SUM_W-1:0])),
      .set_sq             (pop_data[SUM_W +: SQ_W]),
      .set_count          (pop_data[SUM_W+SQ_W +: CNT_W]),
      .set_ovf            (pop_data[SET_W-1]),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mean_value     (rsp_mean_value),
      .rsp_std_deviation  (rsp_std_deviation),
      .rsp_sample_count   (rsp_sample_count),
      .rsp_count_overflow (rsp_count_overflow)
   );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

// One finished set as the result channel presents it.
typedef struct {
   logic signed [smd_pkg::MEAN_W-1:0] mean;
   logic        [smd_pkg::STD_W-1:0]  std;
   logic        [smd_pkg::COUNT_W-1:0] count;
   logic                               overflow;
} set_stats_type;

class set_stats_board #(int FRAC = 8, int LIMIT = 65536);

   longint      acc_sum;
   logic [63:0] acc_square;
   int          acc_count;
   bit          acc_overflow;

   set_stats_type pending_stats[$];
   int          errors;
   int          sets_done;
   int          overflow_sets;

   function new();
      errors        = 0;
      sets_done     = 0;
      overflow_sets = 0;
      clear_acc();
   endfunction

   function void clear_acc();
      acc_sum      = 0;
      acc_square   = '0;
      acc_count    = 0;
      acc_overflow = 1'b0;
   endfunction

   function logic [63:0] int_sqrt(logic [127:0] v);
      logic [63:0] root;
      logic [63:0] cand;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (({64'd0, cand} * {64'd0, cand}) <= v) root = cand;
      end
      return root;
   endfunction

   // Exact one-pass statistics of the set held in the accumulators.
   function set_stats_type finish_set();
      set_stats_type r;
      bit           neg;
      logic [127:0] mag;
      logic [127:0] quo;
      logic [127:0] rem;
      logic [127:0] nq;
      logic [127:0] s2;
      logic [127:0] var_scaled;
      logic [63:0]  root;
      r.mean     = '0;
      r.std      = '0;
      r.count    = smd_pkg::COUNT_W'(acc_count);
      r.overflow = acc_overflow;
      if (!acc_overflow && acc_count >= 1) begin
         neg = acc_sum < 0;
         mag = neg ? 128'(-acc_sum) : 128'(acc_sum);
         quo = (mag << FRAC) / 128'(acc_count);
         rem = (mag << FRAC) % 128'(acc_count);
         if (neg) begin
            // Rounding the magnitude up gives the floor of a negative mean.
            if (rem != 0) quo = quo + 1;
            if (quo > 128'(1 << 23)) quo = 128'(1 << 23);
            r.mean = -quo[23:0];
         end else begin
            if (quo > 128'((1 << 23) - 1)) quo = 128'((1 << 23) - 1);
            r.mean = quo[23:0];
         end
         if (acc_count >= 2) begin
            nq = 128'(acc_square) * 128'(acc_count);
            s2 = mag * mag;
            var_scaled = '0;
            if (nq > s2)
               var_scaled = ((nq - s2) << (2 * FRAC)) /
                            (128'(acc_count) * 128'(acc_count - 1));
            root = int_sqrt(var_scaled);
            r.std = (root > 64'hFF_FFFF) ? 24'hFF_FFFF : root[23:0];
         end
      end
      return r;
   endfunction

   function void note_sample(logic signed [15:0] sample, logic last);
      if (acc_count >= LIMIT) begin
         acc_overflow = 1'b1;
      end else begin
         acc_sum    = acc_sum + longint'(sample);
         acc_square = acc_square + 64'(longint'(sample) * longint'(sample));
         acc_count  = acc_count + 1;
      end
      if (last) begin
         pending_stats.push_back(finish_set());
         clear_acc();
      end
   endfunction

   function void check_result(set_stats_type got);
      set_stats_type want;
      if (pending_stats.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("[%0t] unexpected result: mean %0d std %0d count %0d ovf %0b",
                     $realtime, got.mean, got.std, got.count, got.overflow);
         return;
      end
      want = pending_stats.pop_front();
      sets_done++;
      if (want.overflow) overflow_sets++;
      if (got.mean !== want.mean || got.std !== want.std ||
          got.count !== want.count || got.overflow !== want.overflow) begin
         errors++;
         if (errors <= 10) begin
            $display("[%0t] set %0d mismatch:", $realtime, sets_done);
            $display("   expected mean %0d std %0d count %0d ovf %0b",
                     want.mean, want.std, want.count, want.overflow);
            $display("   actual   mean %0d std %0d count %0d ovf %0b",
                     got.mean, got.std, got.count, got.overflow);
         end
      end
   endfunction

endclass

module tb_top;

   localparam int SAMPLE_BITS  = 16;
   localparam int MAX_COUNT    = 65536;
   localparam int FRAC_BITS    = 8;
   // Roughly how many samples to stream in all, directed sets included.
   localparam int RANDOM_ITEMS = 1850;
   // Quiet time after the last result; comfortably longer than the back end spends on a set.
   localparam int DRAIN_CYCLES = 800;

   // Content styles for a set of samples.
   typedef enum int {
      SET_FULL,
      SET_SMALL,
      SET_EXTREME,
      SET_CONST,
      SET_MIXED
   } set_style_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic                          req_last;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [smd_pkg::MEAN_W-1:0]  rsp_mean_value;
   logic        [smd_pkg::STD_W-1:0]   rsp_std_deviation;
   logic        [smd_pkg::COUNT_W-1:0] rsp_sample_count;
   logic                               rsp_count_overflow;

   set_stats_board #(FRAC_BITS, MAX_COUNT) board;

   // Sender pacing: samples go out in bursts, each followed by a random gap.
   int burst_left;
   int samples_sent;
   int longest_set;

   sequence_mean_stddev #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .MAX_COUNT  (MAX_COUNT),
      .FRAC_BITS  (FRAC_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_mean_value    (rsp_mean_value),
      .rsp_std_deviation (rsp_std_deviation),
      .rsp_sample_count  (rsp_sample_count),
      .rsp_count_overflow(rsp_count_overflow)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Drive one sample and hold it until the transfer happens. The stall seen
   // right after the edge is the value the block sampled at that edge, so the
   // handshake is judged without racing the block's own updates.
   task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] sample,
                              input logic last);
      int gap;
      req_valid  <= 1'b1;
      req_sample <= sample;
      req_last   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_sample(sample, last);
      samples_sent++;
      // At the end of a burst the valid drops for a random gap, which may be zero;
      // no gap comes before a long burst, so there are long stretches with no idling at all.
      burst_left--;
      if (burst_left <= 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(50, 300);
            gap = 0;
         end else begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 7);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
      set_style_type style, logic signed [SAMPLE_BITS-1:0] base);
      set_style_type pick;
      pick = style;
      if (style == SET_MIXED) pick = set_style_type'($urandom_range(0, 2));
      case (pick)
         SET_CONST: return base;
         SET_SMALL: return SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
         SET_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
               1:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
               2:       return '0;
               default: return '1;
            endcase
         end
         default: return SAMPLE_BITS'($urandom_range(0, 65535));
      endcase
   endfunction

   // Stream a whole set, with last raised on its final sample.
   task automatic send_set(input int len, input set_style_type style);
      logic signed [SAMPLE_BITS-1:0] base;
      base = SAMPLE_BITS'($urandom_range(0, 65535));
      for (int i = 0; i < len; i++)
         push_sample(pick_sample(style, base), i == len - 1);
      if (len > longest_set) longest_set = len;
   endtask

   // Result side: check every transfer and stall on a pattern that switches
   // between no stall, light and heavy random stall, and a periodic stall.
   int stall_mode;
   int mode_left;
   int stall_phase;

   always @(posedge clock) begin
      set_stats_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.mean     = rsp_mean_value;
         got.std      = rsp_std_deviation;
         got.count    = rsp_sample_count;
         got.overflow = rsp_count_overflow;
         board.check_result(got);
      end
      if (mode_left <= 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(64, 600);
      end
      mode_left--;
      stall_phase++;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 9) < 3);
         2:       rsp_stall <= ($urandom_range(0, 9) < 8);
         default: rsp_stall <= ((stall_phase % 7) < 3);
      endcase
   end

   // Generous fixed limit: far beyond the slowest correct run, even with
   // every sample closing its own set and the receiver stalling heavily.
   initial begin
      #100_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int r;
      int len;
      board        = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_sample   = '0;
      req_last     = 1'b0;
      rsp_stall    = 1'b0;
      stall_mode   = 0;
      mode_left    = 0;
      stall_phase  = 0;
      burst_left   = 1;
      samples_sent = 0;
      longest_set  = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed sets. Single samples at both extremes and at zero give a
      // deviation of zero by rule.
      push_sample(16'sd32767, 1'b1);
      push_sample(-16'sd32768, 1'b1);
      push_sample(16'sd0, 1'b1);
      // Widest possible spread over two samples.
      push_sample(-16'sd32768, 1'b0);
      push_sample(16'sd32767, 1'b1);
      // Negative mean that is not a whole number, so the floor matters.
      push_sample(-16'sd1, 1'b0);
      push_sample(16'sd0, 1'b0);
      push_sample(16'sd0, 1'b1);
      // Identical samples: the variance term is exactly zero.
      repeat (3) push_sample(16'sd1234, 1'b0);
      push_sample(16'sd1234, 1'b1);
      repeat (2) push_sample(-16'sd32768, 1'b0);
      push_sample(-16'sd32768, 1'b1);
      // Mixed signs.
      push_sample(16'sd100, 1'b0);
      push_sample(-16'sd200, 1'b0);
      push_sample(16'sd300, 1'b0);
      push_sample(-16'sd400, 1'b1);

      // Random sets: mostly short, some medium, a few long.
      while (samples_sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 50)      len = $urandom_range(1, 4);
         else if (r < 85) len = $urandom_range(5, 16);
         else             len = $urandom_range(17, 64);
         r = $urandom_range(0, 99);
         if (r < 10)      send_set(len, SET_CONST);
         else if (r < 25) send_set(len, SET_EXTREME);
         else if (r < 40) send_set(len, SET_SMALL);
         else if (r < 60) send_set(len, SET_MIXED);
         else             send_set(len, SET_FULL);
      end
      req_valid <= 1'b0;
      req_last  <= 1'b0;

      while (board.pending_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d sets from %0d samples; longest set %0d, overflowed sets %0d.",
               board.sets_done, samples_sent, longest_set, board.overflow_sets);
      $display("Sets mixed constant, extreme, small and full-range samples under random stalls.");
      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches in total.", board.errors);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/smd_pkg.sv
hdl/smd_front.sv
hdl/smd_fifo.sv
hdl/smd_back.sv
hdl/sequence_mean_stddev.sv
tb/tb_top.sv
